FILE: src/frc_pkg.sv
// Package for the fraction reducer: shared constants and the command and
// status types that pass between the controller and the datapath.
// No dependencies.
package frc_pkg;

    // Default width of the numerator and denominator fields
    localparam int FRC_VALUE_WIDTH = 31;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_HALVE_BOTH,
        OP_HALVE_A,
        OP_GCD_STEP,
        OP_MAKE_G,
        OP_DIV_STEP,
        OP_CAPTURE
    } frc_op_t;

    typedef struct packed {
        frc_op_t op;
    } frc_cmd_t;

    typedef struct packed {
        logic a_even;
        logic b_even;
        logic b_zero;
        logic n_zero;
        logic d_zero;
        logic div_last;
    } frc_status_t;

endpackage

FILE: src/frc_datapath.sv
// Datapath of the fraction reducer: binary GCD registers, two restoring
// divider lanes sharing the divisor, and the result register.
// Depends on frc_pkg.
module frc_datapath
    import frc_pkg::*;
#(
    parameter int VALUE_WIDTH = FRC_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic [VALUE_WIDTH-1:0] num_in,
    input  logic [VALUE_WIDTH-1:0] den_in,
    input  frc_cmd_t               cmd,
    output frc_status_t            status,
    output logic [VALUE_WIDTH-1:0] num_out,
    output logic [VALUE_WIDTH-1:0] den_out,
    output logic                   zero_den
);

    localparam int W  = VALUE_WIDTH;
    localparam int KW = $clog2(W);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  qn_reg, qn_next;
    logic [W-1:0]  qd_reg, qd_next;
    logic [W-1:0]  rn_reg, rn_next;
    logic [W-1:0]  rd_reg, rd_next;
    logic          zd_reg, zd_next;
    logic [W-1:0]  num_out_reg, num_out_next;
    logic [W-1:0]  den_out_reg, den_out_next;
    logic          zero_den_reg, zero_den_next;

    // GCD subtract: both differences, borrow of b - a says a > b
    logic [W:0] ba_diff;
    logic [W:0] ab_diff;
    assign ba_diff = {1'b0, b_reg} - {1'b0, a_reg};
    assign ab_diff = {1'b0, a_reg} - {1'b0, b_reg};

    // Divider lanes: shift in the next dividend bit, trial subtract
    logic [W:0]   rn_w, rd_w;
    logic [W+1:0] rn_diff, rd_diff;
    logic         qn_bit, qd_bit;
    assign rn_w    = {rn_reg, qn_reg[W-1]};
    assign rd_w    = {rd_reg, qd_reg[W-1]};
    assign rn_diff = {1'b0, rn_w} - {2'b0, a_reg};
    assign rd_diff = {1'b0, rd_w} - {2'b0, a_reg};
    assign qn_bit  = ~rn_diff[W+1];
    assign qd_bit  = ~rd_diff[W+1];

    // Next-state logic per command
    always_comb begin
        a_next        = a_reg;
        b_next        = b_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        qn_next       = qn_reg;
        qd_next       = qd_reg;
        rn_next       = rn_reg;
        rd_next       = rd_reg;
        zd_next       = zd_reg;
        num_out_next  = num_out_reg;
        den_out_next  = den_out_reg;
        zero_den_next = zero_den_reg;
        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                a_next  = num_in;
                b_next  = den_in;
                qn_next = num_in;
                qd_next = den_in;
                rn_next = '0;
                rd_next = '0;
                k_next  = '0;
                zd_next = (den_in == '0);
            end
            OP_HALVE_BOTH: begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + KW'(1);
            end
            OP_HALVE_A: begin
                a_next = a_reg >> 1;
            end
            OP_GCD_STEP: begin
                if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (ba_diff[W]) begin
                    a_next = b_reg;
                    b_next = ab_diff[W-1:0];
                end else begin
                    b_next = ba_diff[W-1:0];
                end
            end
            OP_MAKE_G: begin
                a_next   = a_reg << k_reg;
                cnt_next = CW'(W);
            end
            OP_DIV_STEP: begin
                rn_next  = qn_bit ? rn_diff[W-1:0] : rn_w[W-1:0];
                rd_next  = qd_bit ? rd_diff[W-1:0] : rd_w[W-1:0];
                qn_next  = {qn_reg[W-2:0], qn_bit};
                qd_next  = {qd_reg[W-2:0], qd_bit};
                cnt_next = cnt_reg - CW'(1);
            end
            OP_CAPTURE: begin
                num_out_next  = qn_reg;
                den_out_next  = qd_reg;
                zero_den_next = zd_reg;
            end
            default: begin
            end
        endcase
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        qn_reg       <= qn_next;
        qd_reg       <= qd_next;
        rn_reg       <= rn_next;
        rd_reg       <= rd_next;
        zd_reg       <= zd_next;
        num_out_reg  <= num_out_next;
        den_out_reg  <= den_out_next;
        zero_den_reg <= zero_den_next;
    end

    // Status to the controller
    assign status.a_even   = ~a_reg[0];
    assign status.b_even   = ~b_reg[0];
    assign status.b_zero   = (b_reg == '0);
    assign status.n_zero   = (qn_reg == '0);
    assign status.d_zero   = zd_reg;
    assign status.div_last = (cnt_reg == CW'(1));

    assign num_out  = num_out_reg;
    assign den_out  = den_out_reg;
    assign zero_den = zero_den_reg;

endmodule

FILE: src/frc_ctrl.sv
// Controller of the fraction reducer: sequences load, GCD, division and
// result capture, and owns the handshake state. Depends on frc_pkg.
module frc_ctrl
    import frc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  frc_status_t status,
    output frc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_STRIP_BOTH,
        S_STRIP_A,
        S_LOOP,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = ~out_valid_reg | m_tready;

    // Command and next state
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.d_zero || status.n_zero) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_STRIP_BOTH;
                end
            end
            S_STRIP_BOTH: begin
                if (status.a_even && status.b_even) begin
                    cmd.op = OP_HALVE_BOTH;
                end else begin
                    state_next = S_STRIP_A;
                end
            end
            S_STRIP_A: begin
                if (status.a_even) begin
                    cmd.op = OP_HALVE_A;
                end else begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (status.b_zero) begin
                    cmd.op     = OP_MAKE_G;
                    state_next = S_DIV;
                end else begin
                    cmd.op = OP_GCD_STEP;
                end
            end
            S_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word held until taken
    always_comb begin
        if (cmd.op == OP_CAPTURE) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // No input taken while reset is held
    assign s_tready = (state_reg == S_IDLE) && aresetn;
    assign m_tvalid = out_valid_reg;

endmodule

FILE: src/fraction_reducer.sv
// Top level of the fraction reducer: stream ports, controller and datapath.
// Depends on frc_pkg, frc_ctrl and frc_datapath.
//
// Reduces num/den to lowest terms; a zero denominator passes the word through
// with the zero_den flag set, and a zero numerator passes through unreduced.
// One word is worked on at a time, in order: load, zero checks, halving out the
// common and then the remaining factors of two, the binary GCD loop (one halve
// or one subtract per cycle), scaling of the divisor, the restoring divider,
// which divides numerator and denominator in two parallel lanes, and result
// capture. A zero numerator or denominator goes straight from the checks to
// capture. The result sits in an output register, so the next word is taken
// while it waits.
module fraction_reducer
    import frc_pkg::*;
#(
    parameter int VALUE_WIDTH = FRC_VALUE_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: num_in, den_in (from bit 0 up), zero padded to bytes
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: num_out, den_out (from bit 0 up), zero padded to bytes
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]    m_tdata,
    // m_tuser: zero_den
    output logic                                  m_tuser
);

    localparam int W     = VALUE_WIDTH;
    localparam int DATA_W = ((2 * W + 7) / 8) * 8;

    frc_cmd_t    cmd;
    frc_status_t status;
    logic [W-1:0] num_out;
    logic [W-1:0] den_out;

    frc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frc_datapath #(
        .VALUE_WIDTH (W)
    ) u_datapath (
        .aclk     (aclk),
        .num_in   (s_tdata[W-1:0]),
        .den_in   (s_tdata[2*W-1:W]),
        .cmd      (cmd),
        .status   (status),
        .num_out  (num_out),
        .den_out  (den_out),
        .zero_den (m_tuser)
    );

    assign m_tdata = DATA_W'({den_out, num_out});

`ifndef NO_ASSERTIONS
    // One word at a time: no second accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in progress");

    // Error flag goes with a zero denominator
    a_flag_den_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[2*W-1:W] == '0))
        else $error("zero_den set with nonzero denominator");

    // A reduced fraction never has a zero denominator
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[2*W-1:W] != '0))
        else $error("zero denominator without zero_den");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for fraction_reducer: drives num/den words on the
// input stream and checks each reduced fraction against a built-in GCD model.
// Depends on frc_pkg and the fraction_reducer RTL.
module testbench;
    import frc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = FRC_VALUE_WIDTH;
    localparam int TW          = ((2*VW+7)/8)*8;
    localparam bit [VW-1:0] MAXV = {VW{1'b1}};
    localparam int SETTLE      = 4*VW + 16;
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct packed {
        bit [VW-1:0] num;
        bit [VW-1:0] den;
        bit          zero_den;
    } fraction_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [TW-1:0] s_tdata  = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [TW-1:0] m_tdata;
    logic          m_tuser;

    fraction_t reduced_q[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    bit        rx_hold     = 1'b0;

    fraction_reducer #(.VALUE_WIDTH(VW)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL fraction_reducer");
            $finish;
        end
    end

    // Expected result: lowest terms by Euclid; zero num or den passes through
    function automatic fraction_t reduce_fraction(bit [VW-1:0] n, bit [VW-1:0] d);
        fraction_t   r;
        bit [VW-1:0] a;
        bit [VW-1:0] b;
        bit [VW-1:0] t;
        r.num      = n;
        r.den      = d;
        r.zero_den = (d == 0);
        if (d != 0 && n != 0) begin
            a = n;
            b = d;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            r.num = n / a;
            r.den = d / a;
        end
        return r;
    endfunction

    // Random value of at most w bits
    function automatic bit [VW-1:0] rand_bits(int w);
        bit [31:0] r;
        r = $urandom;
        if (w <= 0)
            return '0;
        return VW'(r & ((32'd1 << w) - 1));
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Send one word; entered and left at a falling edge
    task automatic send_fraction(bit [VW-1:0] n, bit [VW-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= TW'({$urandom, $urandom});
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TW'({d, n});
        do @(posedge aclk); while (!s_tready);
        reduced_q.push_back(reduce_fraction(n, d));
        @(negedge aclk);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (reduced_q.size() != 0)
            @(negedge aclk);
        @(negedge aclk);
    endtask

    // Receiver readiness, with an optional long hold-off
    always @(negedge aclk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    // Compare each output word with the oldest expectation
    always @(posedge aclk) begin
        fraction_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reduced_q.size() == 0) begin
                report_error($sformatf("unexpected word num=%0d den=%0d zero_den=%b",
                    m_tdata[VW-1:0], m_tdata[2*VW-1:VW], m_tuser));
            end else begin
                want = reduced_q.pop_front();
                if (m_tdata[VW-1:0] !== want.num)
                    report_error($sformatf("num_out got %0d expected %0d",
                        m_tdata[VW-1:0], want.num));
                if (m_tdata[2*VW-1:VW] !== want.den)
                    report_error($sformatf("den_out got %0d expected %0d",
                        m_tdata[2*VW-1:VW], want.den));
                if (m_tuser !== want.zero_den)
                    report_error($sformatf("zero_den got %b expected %b",
                        m_tuser, want.zero_den));
            end
        end
    end

    // Extremes, zero cases, reduced fractions and exact multiples
    task automatic test_special_fractions();
        send_fraction(0, 0);
        send_fraction(0, 1);
        send_fraction(0, MAXV);
        send_fraction(MAXV, 0);
        send_fraction(1, 0);
        send_fraction(MAXV, MAXV);
        send_fraction(1, 1);
        send_fraction(MAXV, 1);
        send_fraction(1, MAXV);
        send_fraction(6, 4);
        send_fraction(12, 18);
        send_fraction(7, 9);
        send_fraction(VW'(1) << (VW-1), VW'(1) << (VW-2));
        send_fraction(VW'(1) << (VW-1), VW'(1) << (VW-1));
        send_fraction(VW'(1) << (VW-1), 3);
        send_fraction(MAXV - VW'(1), VW'(1) << (VW-1));
        send_fraction(MAXV, MAXV - VW'(18));
        send_fraction(VW'(7_000_000), 7);
        send_fraction(5, VW'(2_000_000_000));
        send_fraction(VW'(31'h5555_5555), VW'(31'h2AAA_AAAA));
        send_fraction(VW'(31'h2AAA_AAAA), VW'(31'h5555_5555));
        send_fraction(MAXV - VW'(1), MAXV - VW'(1));
    endtask

    // Random words, weighted toward fractions that share a factor
    task automatic test_random_fractions(int count);
        bit [VW-1:0] n;
        bit [VW-1:0] d;
        bit [VW-1:0] g;
        bit [VW-1:0] a;
        bit [VW-1:0] b;
        int          gw;
        int          k;
        int          pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                // common factor of random size
                gw = $urandom_range(1, VW - 1);
                g  = rand_bits(gw) | (VW'(1) << (gw - 1));
                a  = rand_bits($urandom_range(0, VW - gw));
                b  = rand_bits($urandom_range(1, VW - gw));
                n  = VW'(64'(g) * 64'(a));
                d  = VW'(64'(g) * 64'(b));
            end else if (pick < 40) begin
                // common power of two
                k = $urandom_range(1, VW - 1);
                n = rand_bits(VW - k) << k;
                d = rand_bits(VW - k) << k;
            end else if (pick < 65) begin
                n = rand_bits(VW);
                d = rand_bits(VW);
            end else if (pick < 75) begin
                n = VW'($urandom_range(0, 300));
                d = VW'($urandom_range(0, 300));
            end else if (pick < 80) begin
                n = rand_bits($urandom_range(0, VW));
                d = '0;
            end else if (pick < 85) begin
                n = '0;
                d = rand_bits($urandom_range(1, VW));
            end else if (pick < 90) begin
                n = rand_bits($urandom_range(1, VW));
                d = n;
            end else begin
                // one part divides the other
                gw = $urandom_range(1, VW - 1);
                a  = rand_bits(gw);
                b  = rand_bits($urandom_range(0, VW - gw));
                n  = a;
                d  = VW'(64'(a) * 64'(b));
                if ($urandom_range(1)) begin
                    n = d;
                    d = a;
                end
            end
            send_fraction(n, d);
        end
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_output_stall();
        rx_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end
            begin
                repeat (10) send_fraction(rand_bits(VW), rand_bits(VW));
                s_tvalid <= 1'b0;
            end
        join
        @(negedge aclk);
    endtask

    // Sender pauses until the block has delivered everything
    task automatic test_drain_pause();
        repeat (4) send_fraction(rand_bits(VW), rand_bits(VW) | VW'(1));
        wait_drained();
        repeat (4) send_fraction(rand_bits(VW) & ~VW'(1), rand_bits(VW) & ~VW'(1));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 17;
        rx_idle_pct = 47;
        test_special_fractions();
        test_random_fractions(460);

        tx_idle_pct = 47;
        rx_idle_pct = 17;
        test_output_stall();
        test_random_fractions(460);
        test_drain_pause();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_fractions(460);

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (error_count == 0)
            $display("PASS fraction_reducer");
        else
            $display("FAIL fraction_reducer");
        $finish;
    end

endmodule

FILE: sim.f
src/frc_pkg.sv
src/frc_datapath.sv
src/frc_ctrl.sv
src/fraction_reducer.sv
test/testbench.sv
